/* rtl/hvcrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcrd_pkg
// Shared constants, command codes and the control/status bundles of the
// hybrid vector-clock / lockset race detector.
// ----------------------------------------------------------------------------
`default_nettype none

package hvcrd_pkg;

  localparam int unsigned THREADS_DEF    = 8;
  localparam int unsigned LOCKS_DEF      = 16;
  localparam int unsigned VARIABLES_DEF  = 256;
  localparam int unsigned CLOCK_BITS_DEF = 32;

  localparam int unsigned INSTR_W    = 32;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 2;

  localparam int unsigned MAX_RESULTS = 9;
  localparam int unsigned CNT_W       = 4;

  localparam logic [2:0] CMD_FORK    = 3'd0;
  localparam logic [2:0] CMD_JOIN    = 3'd1;
  localparam logic [2:0] CMD_ACQUIRE = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_READ    = 3'd4;
  localparam logic [2:0] CMD_WRITE   = 3'd5;

  localparam logic [1:0] KIND_WR = 2'd0;
  localparam logic [1:0] KIND_WW = 2'd1;
  localparam logic [1:0] KIND_RW = 2'd2;

  typedef struct packed {
    logic clear;
    logic idle;
    logic disp;
    logic merge_rd;
    logic merge_wr;
    logic tick_rd;
    logic tick_wr;
    logic look;
    logic look2;
    logic decide;
    logic walk_rd;
    logic walk_ev;
    logic flush;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic go_merge;
    logic go_tick;
    logic go_look;
    logic idx_last;
    logic skip;
    logic is_write;
    logic walk_stall;
    logic flush_done;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/hvcrd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcrd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                       rdata_a,
  output logic      [WIDTH-1:0]                       rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

/* rtl/hvcrd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcrd_ctrl
// Sequencer: reset clearing pass, dispatch, clock merge/tick and access walk.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcrd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  hvcrd_pkg::sts_t    sts,
  output hvcrd_pkg::ctl_t    ctl
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_DISP     = 13'b0000000000100,
    S_MERGE_RD = 13'b0000000001000,
    S_MERGE_WR = 13'b0000000010000,
    S_TICK_RD  = 13'b0000000100000,
    S_TICK_WR  = 13'b0000001000000,
    S_LOOK     = 13'b0000010000000,
    S_LOOK2    = 13'b0000100000000,
    S_DECIDE   = 13'b0001000000000,
    S_WALK_RD  = 13'b0010000000000,
    S_WALK_EV  = 13'b0100000000000,
    S_FLUSH    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:     if (in_tvalid) state_nxt = S_DISP;
      S_DISP: begin
        if (sts.go_merge)     state_nxt = S_MERGE_RD;
        else if (sts.go_tick) state_nxt = S_TICK_RD;
        else if (sts.go_look) state_nxt = S_LOOK;
        else                  state_nxt = S_IDLE;
      end
      S_MERGE_RD: state_nxt = S_MERGE_WR;
      S_MERGE_WR: state_nxt = sts.idx_last ? S_TICK_RD : S_MERGE_RD;
      S_TICK_RD:  state_nxt = S_TICK_WR;
      S_TICK_WR:  state_nxt = S_IDLE;
      S_LOOK:     state_nxt = S_LOOK2;
      S_LOOK2:    state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (sts.skip)          state_nxt = S_IDLE;
        else if (sts.is_write) state_nxt = S_WALK_RD;
        else                   state_nxt = S_FLUSH;
      end
      S_WALK_RD:  state_nxt = S_WALK_EV;
      S_WALK_EV: begin
        if (!sts.walk_stall) state_nxt = sts.idx_last ? S_FLUSH : S_WALK_RD;
      end
      S_FLUSH:    if (sts.flush_done) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ctl.clear    = (state_r == S_CLEAR);
  assign ctl.idle     = (state_r == S_IDLE);
  assign ctl.disp     = (state_r == S_DISP);
  assign ctl.merge_rd = (state_r == S_MERGE_RD);
  assign ctl.merge_wr = (state_r == S_MERGE_WR);
  assign ctl.tick_rd  = (state_r == S_TICK_RD);
  assign ctl.tick_wr  = (state_r == S_TICK_WR);
  assign ctl.look     = (state_r == S_LOOK);
  assign ctl.look2    = (state_r == S_LOOK2);
  assign ctl.decide   = (state_r == S_DECIDE);
  assign ctl.walk_rd  = (state_r == S_WALK_RD);
  assign ctl.walk_ev  = (state_r == S_WALK_EV);
  assign ctl.flush    = (state_r == S_FLUSH);

endmodule

`default_nettype wire

/* rtl/hvcrd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcrd_dp
// Datapath: item latch, thread flags and lock masks, clock / write-epoch /
// read-epoch memories, race checks, pending record and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcrd_dp #(
  parameter int unsigned THREADS    = hvcrd_pkg::THREADS_DEF,
  parameter int unsigned LOCKS      = hvcrd_pkg::LOCKS_DEF,
  parameter int unsigned VARIABLES  = hvcrd_pkg::VARIABLES_DEF,
  parameter int unsigned CLOCK_BITS = hvcrd_pkg::CLOCK_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_fire,
  input  wire logic [hvcrd_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [hvcrd_pkg::IN_USER_W-1:0]   in_tuser,
  input  hvcrd_pkg::ctl_t                        ctl,
  output hvcrd_pkg::sts_t                        sts,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [hvcrd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic      [hvcrd_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                                   out_tlast
);

  localparam int unsigned TW     = $clog2(THREADS);
  localparam int unsigned VW     = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;
  localparam int unsigned CDEPTH = THREADS * THREADS;
  localparam int unsigned CAW    = $clog2(CDEPTH);
  localparam int unsigned RDEPTH = VARIABLES * THREADS;
  localparam int unsigned RAW    = $clog2(RDEPTH);
  localparam int unsigned IW     = hvcrd_pkg::INSTR_W;
  localparam int unsigned CB     = CLOCK_BITS;
  localparam int unsigned WS_LK  = IW;
  localparam int unsigned WS_CK  = IW + LOCKS;
  localparam int unsigned WS_T   = IW + LOCKS + CB;
  localparam int unsigned WSW    = WS_T + TW;
  localparam int unsigned RSW    = IW + LOCKS + CB + 1;
  localparam int unsigned CLR_N  = (RDEPTH > CDEPTH) ? RDEPTH : CDEPTH;
  localparam int unsigned CLW    = $clog2(CLR_N) + 1;
  localparam int unsigned CNTW   = hvcrd_pkg::CNT_W;

  // item latch
  logic [2:0]    cmd_r, t_r, u_r;
  logic [3:0]    lk_r;
  logic [7:0]    v_r;
  logic          stack_r;
  logic [IW-1:0] instr_r;

  logic [THREADS-1:0] seen_r;
  logic [LOCKS-1:0]   locks_r [THREADS];
  logic               uinit_r;
  logic [TW-1:0]      idx_r;
  logic [CNTW-1:0]    cnt_r;
  logic [CLW-1:0]     clr_r;

  logic [CB-1:0]      own_r, wclk_r;
  logic [TW-1:0]      wt_r;
  logic [LOCKS-1:0]   wlk_r;
  logic [IW-1:0]      winstr_r;

  logic               pend_v_r;
  logic [1:0]         pend_kind_r;
  logic [IW-1:0]      pend_first_r;
  logic               out_v_r, out_last_r;
  logic [1:0]         out_kind_r;
  logic [IW-1:0]      out_first_r, out_second_r;
  logic [7:0]         out_var_r;

  // memory ports
  logic           c_we;
  logic [CAW-1:0] c_wa, c_ra, c_rb;
  logic [CB-1:0]  c_wd, c_qa, c_qb;
  logic           w_we;
  logic [VW-1:0]  w_wa, w_ra;
  logic [WSW-1:0] w_wd, w_q;
  logic           r_we;
  logic [RAW-1:0] r_wa, r_ra;
  logic [RSW-1:0] r_wd, r_q;

  function automatic logic [CAW-1:0] caddr(input logic [TW-1:0] row,
                                           input logic [TW-1:0] col);
    caddr = CAW'(row) * CAW'(THREADS) + CAW'(col);
  endfunction

  function automatic logic [RAW-1:0] raddr(input logic [VW-1:0] var_ix,
                                           input logic [TW-1:0] col);
    raddr = RAW'(var_ix) * RAW'(THREADS) + RAW'(col);
  endfunction

  // decode
  logic is_fork, is_join, is_acq, is_rel, is_read, is_write;
  logic t_ok, u_ok, v_ok, lk_ok, ev_ok;
  logic [TW-1:0] tix, uix, dst, src, trow;
  logic [VW-1:0] vix;
  logic [LOCKS-1:0] lk_mask, held;
  logic [THREADS-1:0] t_bit, u_bit;

  assign is_fork  = (cmd_r == hvcrd_pkg::CMD_FORK);
  assign is_join  = (cmd_r == hvcrd_pkg::CMD_JOIN);
  assign is_acq   = (cmd_r == hvcrd_pkg::CMD_ACQUIRE);
  assign is_rel   = (cmd_r == hvcrd_pkg::CMD_RELEASE);
  assign is_read  = (cmd_r == hvcrd_pkg::CMD_READ);
  assign is_write = (cmd_r == hvcrd_pkg::CMD_WRITE);

  assign t_ok  = (32'(t_r) < THREADS);
  assign u_ok  = (32'(u_r) < THREADS);
  assign v_ok  = (32'(v_r) < VARIABLES);
  assign lk_ok = (32'(lk_r) < LOCKS);
  assign ev_ok = (is_fork | is_join | is_acq | is_rel | is_read | is_write) && t_ok &&
                 (!(is_fork || is_join) || u_ok);

  assign tix  = TW'(t_r);
  assign uix  = TW'(u_r);
  assign vix  = VW'(v_r);
  assign dst  = is_fork ? uix : tix;
  assign src  = is_fork ? tix : uix;
  assign trow = is_join ? uix : tix;
  assign held = locks_r[tix];

  // one-hot thread marks for the seen flags
  assign t_bit = THREADS'(1) << tix;
  assign u_bit = THREADS'(1) << uix;

  always_comb begin
    for (int j = 0; j < LOCKS; j++) begin
      lk_mask[j] = lk_ok && (32'(lk_r) == j);
    end
  end

  // merge operands; an unseen fork child starts from a fresh row
  logic [CB-1:0] init_val, eff_a, eff_b, mrg_val, tick_val;
  assign init_val = (idx_r == uix) ? CB'(1) : '0;
  assign eff_a    = (is_fork && uinit_r) ? init_val : c_qa;
  assign eff_b    = (is_fork && uinit_r && (tix == uix)) ? init_val : c_qb;
  assign mrg_val  = (eff_a < eff_b) ? eff_b : eff_a;
  assign tick_val = (c_qa == {CB{1'b1}}) ? c_qa : c_qa + CB'(1);

  // access checks
  logic          r_valid;
  logic [CB-1:0] r_clk;
  logic [LOCKS-1:0] r_lk, new_wlk;
  logic [IW-1:0] r_instr;
  logic same_w, w_ord, skip, dec_emit, hit, walk_stall, out_ok, pend_ok;
  logic emit_v, flush_push;
  logic [1:0] emit_kind;
  logic [IW-1:0] emit_first;

  assign r_valid = r_q[RSW-1];
  assign r_clk   = r_q[IW+LOCKS +: CB];
  assign r_lk    = r_q[IW +: LOCKS];
  assign r_instr = r_q[IW-1:0];

  assign same_w  = (wt_r == tix) && (wclk_r == own_r);
  assign w_ord   = (wclk_r <= c_qa);
  assign skip    = is_write ? same_w : ((r_valid && (r_clk == own_r)) || same_w);
  assign new_wlk = w_ord ? held : (wlk_r & held);
  assign dec_emit = !w_ord && (is_write ? (new_wlk == '0) : ((held & wlk_r) == '0));

  assign hit = r_valid && (r_clk > c_qa) && ((r_lk & held) == '0) &&
               (cnt_r < CNTW'(hvcrd_pkg::MAX_RESULTS));

  assign out_ok     = !out_v_r || out_tready;
  assign pend_ok    = !pend_v_r || out_ok;
  assign walk_stall = hit && !pend_ok;

  assign emit_v = (ctl.decide && !skip && dec_emit) || (ctl.walk_ev && hit && !walk_stall);
  assign emit_kind  = ctl.decide ? (is_write ? hvcrd_pkg::KIND_WW : hvcrd_pkg::KIND_WR)
                                 : hvcrd_pkg::KIND_RW;
  assign emit_first = ctl.decide ? winstr_r : r_instr;
  assign flush_push = ctl.flush && pend_v_r && out_ok;

  // clock memory
  always_comb begin
    c_ra = '0;
    c_rb = '0;
    c_we = 1'b0;
    c_wa = '0;
    c_wd = '0;
    if (ctl.merge_rd) begin
      c_ra = caddr(dst, idx_r);
      c_rb = caddr(src, idx_r);
    end else if (ctl.tick_rd) begin
      c_ra = caddr(trow, trow);
    end else if (ctl.look) begin
      c_ra = caddr(tix, tix);
    end else if (ctl.look2) begin
      c_ra = caddr(tix, w_q[WS_T +: TW]);
    end else if (ctl.walk_rd || ctl.walk_ev) begin
      c_ra = caddr(tix, idx_r);
    end
    if (ctl.clear) begin
      c_we = (32'(clr_r) < CDEPTH);
      c_wa = clr_r[CAW-1:0];
      c_wd = (clr_r == '0) ? CB'(1) : '0;
    end else if (ctl.merge_wr) begin
      c_we = 1'b1;
      c_wa = caddr(dst, idx_r);
      c_wd = mrg_val;
    end else if (ctl.tick_wr) begin
      c_we = 1'b1;
      c_wa = caddr(trow, trow);
      c_wd = tick_val;
    end
  end

  // write-epoch memory
  always_comb begin
    w_ra = vix;
    w_we = 1'b0;
    w_wa = vix;
    w_wd = {tix, own_r, new_wlk, instr_r};
    if (ctl.clear) begin
      w_we = (32'(clr_r) < VARIABLES);
      w_wa = clr_r[VW-1:0];
      w_wd = '0;
    end else if (ctl.decide && is_write && !skip) begin
      w_we = 1'b1;
    end
  end

  // read-epoch memory
  always_comb begin
    r_ra = (ctl.look2 || ctl.decide) ? raddr(vix, tix) : raddr(vix, idx_r);
    r_we = 1'b0;
    r_wa = raddr(vix, idx_r);
    r_wd = '0;
    if (ctl.clear) begin
      r_we = (32'(clr_r) < RDEPTH);
      r_wa = clr_r[RAW-1:0];
    end else if (ctl.decide && is_read && !skip) begin
      r_we = 1'b1;
      r_wa = raddr(vix, tix);
      r_wd = {1'b1, own_r, held, instr_r};
    end else if (ctl.walk_ev && !walk_stall) begin
      r_we = 1'b1;
    end
  end

  hvcrd_ram #(.WIDTH(CB), .DEPTH(CDEPTH)) u_clk_ram (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd),
    .raddr_a(c_ra), .raddr_b(c_rb), .rdata_a(c_qa), .rdata_b(c_qb)
  );

  hvcrd_ram #(.WIDTH(WSW), .DEPTH(VARIABLES)) u_wr_ram (
    .clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd),
    .raddr_a(w_ra), .raddr_b(w_ra), .rdata_a(w_q), .rdata_b()
  );

  hvcrd_ram #(.WIDTH(RSW), .DEPTH(RDEPTH)) u_rd_ram (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd),
    .raddr_a(r_ra), .raddr_b(r_ra), .rdata_a(r_q), .rdata_b()
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_tuser[2:0];
      stack_r <= in_tuser[3];
      t_r     <= in_tdata[2:0];
      u_r     <= in_tdata[5:3];
      lk_r    <= in_tdata[9:6];
      v_r     <= in_tdata[17:10];
      instr_r <= in_tdata[49:18];
    end
    if (ctl.disp) begin
      uinit_r <= !seen_r[uix];
    end
    if (ctl.look2) begin
      own_r    <= c_qa;
      wt_r     <= w_q[WS_T +: TW];
      wclk_r   <= w_q[WS_CK +: CB];
      wlk_r    <= w_q[WS_LK +: LOCKS];
      winstr_r <= w_q[IW-1:0];
    end
    if (emit_v) begin
      pend_kind_r  <= emit_kind;
      pend_first_r <= emit_first;
    end
    if ((emit_v && pend_v_r) || flush_push) begin
      out_kind_r   <= pend_kind_r;
      out_first_r  <= pend_first_r;
      out_second_r <= instr_r;
      out_var_r    <= v_r;
      out_last_r   <= flush_push;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= THREADS'(1);
      for (int i = 0; i < THREADS; i++) begin
        locks_r[i] <= '0;
      end
      idx_r    <= '0;
      cnt_r    <= '0;
      clr_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (ctl.clear && (clr_r != CLW'(CLR_N))) begin
        clr_r <= clr_r + CLW'(1);
      end
      if (ctl.disp && ev_ok) begin
        if (is_fork) begin
          seen_r       <= seen_r | t_bit | u_bit;
          locks_r[uix] <= locks_r[tix];
        end else if (is_join) begin
          seen_r <= seen_r | t_bit | u_bit;
        end else if (is_acq) begin
          locks_r[tix] <= locks_r[tix] | lk_mask;
        end else begin
          seen_r <= seen_r | t_bit;
          if (is_rel) begin
            locks_r[tix] <= locks_r[tix] & ~lk_mask;
          end
        end
      end
      if (ctl.disp || ctl.decide) begin
        idx_r <= '0;
      end else if (ctl.merge_wr || (ctl.walk_ev && !walk_stall)) begin
        idx_r <= idx_r + TW'(1);
      end
      if (ctl.disp) begin
        cnt_r <= '0;
      end else if (emit_v) begin
        cnt_r <= cnt_r + CNTW'(1);
      end
      if (emit_v) begin
        pend_v_r <= 1'b1;
      end else if (flush_push) begin
        pend_v_r <= 1'b0;
      end
      if ((emit_v && pend_v_r) || flush_push) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign sts.clr_done   = (clr_r == CLW'(CLR_N));
  assign sts.go_merge   = ev_ok && (is_fork || is_join);
  assign sts.go_tick    = ev_ok && is_rel;
  assign sts.go_look    = ev_ok && (is_read || is_write) && !stack_r && v_ok;
  assign sts.idx_last   = (idx_r == TW'(THREADS - 1));
  assign sts.skip       = skip;
  assign sts.is_write   = is_write;
  assign sts.walk_stall = walk_stall;
  assign sts.flush_done = !pend_v_r || out_ok;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_var_r, out_second_r, out_first_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.idle |-> !pend_v_r) else $error("pending record left over at idle");
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(hvcrd_pkg::MAX_RESULTS)) else $error("record count over cap");
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    flush_push |=> out_v_r && out_last_r) else $error("flush did not mark last");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit_v && pend_v_r |-> out_ok) else $error("output register overwritten");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |-> !out_v_r && !pend_v_r) else $error("records during clear");

endmodule

`default_nettype wire

/* rtl/hybrid_vector_clock_race_detector_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_vector_clock_race_detector_top
// Thread-event race detector: vector clocks plus locksets per variable.
// ----------------------------------------------------------------------------
// One event is in flight at a time, and any output stall holds it up.
// The per-thread walk over the clock and read-epoch memories reads each thread
//   entry, then evaluates/writes it; an output stall holds the walk.
// Reset (rst_n low, synchronous) clears control state, then a clearing pass
//   zeroes the memories and seeds thread 0's clock; in_tready stays low during
//   that pass.
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_vector_clock_race_detector_top #(
  parameter int unsigned THREADS    = hvcrd_pkg::THREADS_DEF,
  parameter int unsigned LOCKS      = hvcrd_pkg::LOCKS_DEF,
  parameter int unsigned VARIABLES  = hvcrd_pkg::VARIABLES_DEF,
  parameter int unsigned CLOCK_BITS = hvcrd_pkg::CLOCK_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // thread_id[2:0], other_thread[5:3], lock_id[9:6], var_id[17:10],
  // instruction_id[49:18], zero pad[55:50]
  input  wire logic [hvcrd_pkg::IN_DATA_W-1:0]   in_tdata,
  // command[2:0], is_stack[3]
  input  wire logic [hvcrd_pkg::IN_USER_W-1:0]   in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // first_instruction[31:0], second_instruction[63:32], race_var[71:64]
  output logic      [hvcrd_pkg::OUT_DATA_W-1:0]  out_tdata,
  // race_kind[1:0]
  output logic      [hvcrd_pkg::OUT_USER_W-1:0]  out_tuser,
  output logic                                   out_tlast
);

  hvcrd_pkg::ctl_t ctl;
  hvcrd_pkg::sts_t sts;

  // new events only enter from idle; the output register decouples results
  assign in_tready = ctl.idle;

  hvcrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .ctl       (ctl)
  );

  hvcrd_dp #(
    .THREADS    (THREADS),
    .LOCKS      (LOCKS),
    .VARIABLES  (VARIABLES),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_tvalid & in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* test/hvcrd_race_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvcrd_race_checker
// Watches the event and race-record channels of the race detector, keeps
// its own vector clocks, locksets and epochs, and checks every record.
// ----------------------------------------------------------------------------
`default_nettype none

module hvcrd_race_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [hvcrd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [hvcrd_pkg::IN_USER_W-1:0]  in_tuser,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [hvcrd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic [hvcrd_pkg::OUT_USER_W-1:0] out_tuser,
  input  wire logic                             out_tlast,
  output int                                    pending_races,
  output int                                    error_count
);

  localparam int NT = hvcrd_pkg::THREADS_DEF;
  localparam int NV = hvcrd_pkg::VARIABLES_DEF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first_ins;
    logic [31:0] second_ins;
    logic [7:0]  var_id;
    logic        last;
  } race_rec_t;

  race_rec_t race_q[$];

  logic [31:0] vclk [NT][NT];
  logic        seen [NT];
  logic [15:0] held_locks [NT];
  logic [2:0]  wr_thread [NV];
  logic [31:0] wr_clock [NV];
  logic [15:0] wr_locks [NV];
  logic [31:0] wr_ins [NV];
  logic        rd_valid [NV][NT];
  logic [31:0] rd_clock [NV][NT];
  logic [15:0] rd_locks [NV][NT];
  logic [31:0] rd_ins [NV][NT];

  task automatic clear_model();
    for (int a = 0; a < NT; a++) begin
      for (int b = 0; b < NT; b++) vclk[a][b] = '0;
      seen[a] = 1'b0;
      held_locks[a] = '0;
    end
    for (int x = 0; x < NV; x++) begin
      wr_thread[x] = '0; wr_clock[x] = '0; wr_locks[x] = '0; wr_ins[x] = '0;
      for (int a = 0; a < NT; a++) begin
        rd_valid[x][a] = 1'b0; rd_clock[x][a] = '0;
        rd_locks[x][a] = '0; rd_ins[x][a] = '0;
      end
    end
    vclk[0][0] = 32'd1;
    seen[0] = 1'b1;
  endtask

  // saturating own-clock increment
  task automatic bump(input int th);
    if (vclk[th][th] != '1) vclk[th][th] = vclk[th][th] + 32'd1;
  endtask

  task automatic absorb(input int dst, input int src);
    for (int i = 0; i < NT; i++)
      if (vclk[dst][i] < vclk[src][i]) vclk[dst][i] = vclk[src][i];
  endtask

  // Apply one event beat and queue the race records it raises.
  task automatic apply_event(input logic [2:0] cmd, input logic [2:0] t,
                             input logic [2:0] u, input logic [3:0] lk,
                             input logic [7:0] v, input logic stk,
                             input logic [31:0] ins);
    race_rec_t   recs[$];
    race_rec_t   r;
    logic [31:0] own;
    logic [15:0] held;
    logic        same_w, ordered;
    case (cmd)
      hvcrd_pkg::CMD_FORK: begin
        if (!seen[u]) begin
          for (int i = 0; i < NT; i++) vclk[u][i] = '0;
          vclk[u][u] = 32'd1;
          seen[u] = 1'b1;
        end
        seen[t] = 1'b1;
        held_locks[u] = held_locks[t];
        absorb(u, t);
        bump(t);
      end
      hvcrd_pkg::CMD_JOIN: begin
        seen[t] = 1'b1;
        seen[u] = 1'b1;
        absorb(t, u);
        bump(u);
      end
      hvcrd_pkg::CMD_ACQUIRE: held_locks[t][lk] = 1'b1;
      hvcrd_pkg::CMD_RELEASE: begin
        held_locks[t][lk] = 1'b0;
        seen[t] = 1'b1;
        bump(t);
      end
      hvcrd_pkg::CMD_READ, hvcrd_pkg::CMD_WRITE: begin
        seen[t] = 1'b1;
        if (!stk) begin
          own     = vclk[t][t];
          held    = held_locks[t];
          same_w  = (wr_thread[v] == t) && (wr_clock[v] == own);
          ordered = wr_clock[v] <= vclk[t][wr_thread[v]];
          if (cmd == hvcrd_pkg::CMD_READ) begin
            if (!(rd_valid[v][t] && rd_clock[v][t] == own) && !same_w) begin
              rd_valid[v][t] = 1'b1;
              rd_clock[v][t] = own;
              rd_ins[v][t]   = ins;
              rd_locks[v][t] = held;
              if (!ordered && (held & wr_locks[v]) == '0) begin
                r = '{hvcrd_pkg::KIND_WR, wr_ins[v], ins, v, 1'b0};
                recs = {recs, r};
              end
            end
          end else if (!same_w) begin
            if (!ordered) begin
              wr_locks[v] = wr_locks[v] & held;
              if (wr_locks[v] == '0) begin
                r = '{hvcrd_pkg::KIND_WW, wr_ins[v], ins, v, 1'b0};
                recs = {recs, r};
              end
            end else begin
              wr_locks[v] = held;
            end
            wr_thread[v] = t;
            wr_clock[v]  = own;
            wr_ins[v]    = ins;
            // read-write records in ascending thread order
            for (int i = 0; i < NT; i++) begin
              if (rd_valid[v][i] && rd_clock[v][i] > vclk[t][i] &&
                  (rd_locks[v][i] & held) == '0 &&
                  recs.size() < hvcrd_pkg::MAX_RESULTS) begin
                r = '{hvcrd_pkg::KIND_RW, rd_ins[v][i], ins, v, 1'b0};
                recs = {recs, r};
              end
              rd_valid[v][i] = 1'b0; rd_clock[v][i] = '0;
              rd_locks[v][i] = '0;   rd_ins[v][i]   = '0;
            end
          end
        end
      end
      default: ;
    endcase
    if (recs.size() > 0) recs[recs.size()-1].last = 1'b1;
    foreach (recs[k]) begin
      r = recs[k];
      race_q = {race_q, r};
    end
  endtask

  always @(posedge clk) begin
    race_rec_t got, want;
    if (!rst_n) begin
      clear_model();
      race_q.delete();
      error_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[71:64],
                out_tlast};
        if (race_q.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10)
            $display("unexpected race beat: %p", got);
        end else begin
          want = race_q.pop_front();
          if (got !== want) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("race mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_event(in_tuser[2:0], in_tdata[2:0], in_tdata[5:3], in_tdata[9:6],
                    in_tdata[17:10], in_tuser[3], in_tdata[49:18]);
    end
  end

  initial error_count = 0;
  assign pending_races = race_q.size();

endmodule

`default_nettype wire

/* test/hybrid_vector_clock_race_detector_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_vector_clock_race_detector_top_tb
// Drives thread events into the race detector (directed cases, then random
// fork/join/lock/access traffic on a few hot variables) under random gaps
// and output backpressure; a side checker predicts and compares records.
// ----------------------------------------------------------------------------
`default_nettype none

module hybrid_vector_clock_race_detector_top_tb;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [hvcrd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [hvcrd_pkg::IN_USER_W-1:0]  in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [hvcrd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [hvcrd_pkg::OUT_USER_W-1:0] out_tuser;
  logic                             out_tlast;
  int                               pending_races;
  int                               error_count;

  // calm: no idling on either side; hold_req: ask the receiver for a long stall
  logic calm;
  logic hold_req;

  hybrid_vector_clock_race_detector_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  hvcrd_race_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .pending_races(pending_races), .error_count(error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: a wide margin over the clearing pass and the ~300 events.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: ~10% random stalls, none while calm. On hold_req it holds
  // tready low for a long stretch so records back up and the input stalls.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // One event beat: optional random gap, then hold valid until accepted.
  // tvalid is only lowered when a gap follows, so it never toggles in a step.
  // tready only moves at rising edges, so it is looked at mid-cycle.
  task automatic send_event(input logic [2:0] cmd, input logic [2:0] t,
                            input logic [2:0] u, input logic [3:0] lk,
                            input logic [7:0] v, input logic stk,
                            input logic [31:0] ins);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, ins, v, lk, u, t};
    in_tuser  <= {stk, cmd};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [2:0] cmd;
    int         pick;
    int         waited;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    send_event(hvcrd_pkg::CMD_FORK,    3'd0, 3'd1, 4'd0,  8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_WRITE,   3'd0, 3'd0, 4'd0,  8'd1,   1'b0, 32'h0000_0011);
    send_event(hvcrd_pkg::CMD_WRITE,   3'd1, 3'd0, 4'd0,  8'd1,   1'b0, 32'h0000_0012);
    // ww race
    send_event(hvcrd_pkg::CMD_WRITE,   3'd0, 3'd0, 4'd0,  8'd1,   1'b0, 32'hFFFF_FFFF);
    // same epoch
    send_event(hvcrd_pkg::CMD_WRITE,   3'd0, 3'd0, 4'd0,  8'd1,   1'b0, 32'h0000_0013);
    // wr race
    send_event(hvcrd_pkg::CMD_READ,    3'd1, 3'd0, 4'd0,  8'd1,   1'b0, 32'h0000_0014);
    // repeated
    send_event(hvcrd_pkg::CMD_READ,    3'd1, 3'd0, 4'd0,  8'd1,   1'b0, 32'h0000_0015);
    send_event(hvcrd_pkg::CMD_FORK,    3'd0, 3'd7, 4'd0,  8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_READ,    3'd7, 3'd0, 4'd0,  8'd255, 1'b0, 32'h0000_0021);
    send_event(hvcrd_pkg::CMD_READ,    3'd1, 3'd0, 4'd0,  8'd255, 1'b0, 32'h0000_0022);
    // rw races
    send_event(hvcrd_pkg::CMD_WRITE,   3'd0, 3'd0, 4'd0,  8'd255, 1'b0, 32'h0000_0023);
    // a common lock suppresses the race
    send_event(hvcrd_pkg::CMD_ACQUIRE, 3'd1, 3'd0, 4'd15, 8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_ACQUIRE, 3'd7, 3'd0, 4'd15, 8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_WRITE,   3'd1, 3'd0, 4'd0,  8'd4,   1'b0, 32'h0000_0031);
    send_event(hvcrd_pkg::CMD_WRITE,   3'd7, 3'd0, 4'd0,  8'd4,   1'b0, 32'h0000_0032);
    send_event(hvcrd_pkg::CMD_RELEASE, 3'd7, 3'd0, 4'd15, 8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_RELEASE, 3'd1, 3'd0, 4'd0,  8'd0,   1'b0, 32'd0);
    // stack access and unknown commands are ignored
    send_event(hvcrd_pkg::CMD_WRITE,   3'd7, 3'd0, 4'd0,  8'd4,   1'b1, 32'h0000_0041);
    send_event(3'd6,                   3'd2, 3'd3, 4'd1,  8'd4,   1'b0, 32'h0000_0042);
    send_event(3'd7,                   3'd7, 3'd7, 4'd15, 8'd255, 1'b1, 32'hFFFF_FFFF);
    send_event(hvcrd_pkg::CMD_JOIN,    3'd0, 3'd1, 4'd0,  8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_JOIN,    3'd0, 3'd7, 4'd0,  8'd0,   1'b0, 32'd0);
    send_event(hvcrd_pkg::CMD_WRITE,   3'd0, 3'd0, 4'd0,  8'd4,   1'b0, 32'h0000_0051);

    // --- random: hot variables so accesses collide ---
    for (int n = 0; n < 250; n++) begin
      calm = (n >= 100 && n < 160);
      if (n == 200) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8)       cmd = hvcrd_pkg::CMD_FORK;
      else if (pick < 14) cmd = hvcrd_pkg::CMD_JOIN;
      else if (pick < 24) cmd = hvcrd_pkg::CMD_ACQUIRE;
      else if (pick < 34) cmd = hvcrd_pkg::CMD_RELEASE;
      else if (pick < 64) cmd = hvcrd_pkg::CMD_READ;
      else if (pick < 97) cmd = hvcrd_pkg::CMD_WRITE;
      else                cmd = 3'($urandom_range(6, 7));
      send_event(cmd, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                 4'($urandom_range(0, 15)),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 5)),
                 $urandom_range(0, 9) == 0, $urandom());
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // drain, then let the last event settle
    @(posedge clk);
    waited = 0;
    while (pending_races != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_races == 0 && error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
